// ===== hw/rtl/motion_window_event_classifier_defines.svh =====
// Assertion helpers for the classifier RTL.
`ifndef MOTION_WINDOW_EVENT_CLASSIFIER_DEFINES_SVH
`define MOTION_WINDOW_EVENT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MWEC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MWEC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mwec_pkg.sv =====
package mwec_pkg;

  localparam int WINDOW_CAP  = 32;
  localparam int CNT_W       = $clog2(WINDOW_CAP + 1);
  localparam int MAG_W       = 16;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic CFG_COOLDOWN = 1'b0;
  localparam logic CFG_MIN_CONF = 1'b1;

  localparam logic [1:0] ST_REJECTED = 2'd0;
  localparam logic [1:0] ST_DOSE     = 2'd1;
  localparam logic [1:0] ST_COOLDOWN = 2'd2;

  localparam logic [1:0] CLS_ACTUATION = 2'd0;
  localparam logic [1:0] CLS_SHAKE     = 2'd1;
  localparam logic [1:0] CLS_DROP      = 2'd2;
  localparam logic [1:0] CLS_STATIC    = 2'd3;

  localparam logic [6:0] CONF_ACTUATION = 7'd85;
  localparam logic [6:0] CONF_SHAKE     = 7'd72;
  localparam logic [6:0] CONF_DROP      = 7'd80;
  localparam logic [6:0] CONF_STATIC    = 7'd90;
  localparam logic [6:0] CONF_NONE      = 7'd0;

  localparam logic [15:0] COOLDOWN_RESET = 16'd2000;
  localparam logic [6:0]  MIN_CONF_RESET = 7'd70;

  // thresholds in raw counts of 1/2048 g
  localparam logic [15:0] P_ACT_LO   = 16'd6144;
  localparam logic [15:0] P_ACT_HI   = 16'd20480;
  localparam logic [15:0] P_SHAKE_LO = 16'd4096;
  localparam logic [15:0] P_SHAKE_HI = 16'd8192;
  localparam logic [15:0] P_DROP     = 16'd20480;
  localparam logic [15:0] J_ACT      = 16'd10240;

  localparam logic [6:0] N_ACT_MAX   = 7'd26;
  localparam logic [6:0] N_SHAKE_MIN = 7'd16;
  localparam logic [6:0] N_DROP_MAX  = 7'd10;

  // milli-g = p * 1000 >> 11; duration = n * 125 / 13 via 2^20 reciprocal
  localparam logic [25:0] MILLI_G_SCALE = 26'd1000;
  localparam logic [12:0] DUR_SCALE     = 13'd125;
  localparam logic [29:0] RECIP_13      = 30'd80660;

  typedef struct packed {
    logic busy;
    logic done;
  } mag_stat_t;

endpackage

// ===== hw/rtl/mwec_mag_unit.sv =====
module mwec_mag_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [15:0]              x_in,
  input  logic signed [15:0]              y_in,
  input  logic signed [15:0]              z_in,
  output logic [mwec_pkg::MAG_W-1:0]      mag,
  output mwec_pkg::mag_stat_t             stat
);

  typedef enum logic [1:0] {M_IDLE, M_SQUARE, M_ROOT} mstate_t;

  mstate_t            state;
  logic signed [15:0] ax, ay, az;
  logic [1:0]         sq_idx;
  logic [3:0]         root_idx;
  logic [31:0]        acc;
  logic [31:0]        rad;
  logic [16:0]        rem;
  logic [15:0]        root;
  logic               done;

  logic signed [15:0] mul_op;
  logic signed [31:0] prod;
  logic [31:0]        acc_next;
  logic [18:0]        rem_sh, trial, rem_diff;

  always_comb begin
    case (sq_idx)
      2'd0:    mul_op = ax;
      2'd1:    mul_op = ay;
      default: mul_op = az;
    endcase
    prod     = 32'(mul_op) * 32'(mul_op);
    // sum of three squares stays below 2^32
    acc_next = acc + $unsigned(prod);
    // one root bit per step, two radicand bits shifted in
    rem_sh   = {rem, rad[31:30]};
    trial    = {1'b0, root, 2'b01};
    rem_diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            ax     <= x_in;
            ay     <= y_in;
            az     <= z_in;
            acc    <= '0;
            sq_idx <= 2'd0;
            state  <= M_SQUARE;
          end
        end
        M_SQUARE: begin
          acc    <= acc_next;
          sq_idx <= sq_idx + 2'd1;
          if (sq_idx == 2'd2) begin
            rad      <= acc_next;
            rem      <= '0;
            root     <= '0;
            root_idx <= '0;
            state    <= M_ROOT;
          end
        end
        M_ROOT: begin
          rad <= {rad[29:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_diff[16:0];
            root <= {root[14:0], 1'b1};
          end else begin
            rem  <= rem_sh[16:0];
            root <= {root[14:0], 1'b0};
          end
          root_idx <= root_idx + 4'd1;
          if (root_idx == 4'hF) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign mag       = root;
  assign stat.busy = (state != M_IDLE);
  assign stat.done = done;

endmodule

// ===== hw/rtl/motion_window_event_classifier.sv =====
// Motion window event classifier.
// Input channel (in_valid/in_ready): one word per sample (op sample) or a
// dose-counter clear (op clear). A window is the run of samples up to the one
// with last_sample set; samples past the window limit add no data but still end it.
// Each sample passes the magnitude unit before the next in_ready: the shared
// 16x16 squarer, the bit-serial square root (one root bit per cycle), then
// the peak/jerk update. A clear or an ignored sample leaves in_ready high. The
// last sample adds a decision step, which puts the result word in the output
// register (out_valid/out_ready): one word per window, none for other inputs.
// A stalled receiver does not block sampling: the next window is accepted
// while a result waits; only the next window's decision cycle waits until the
// output register is free.
// Reset (rst, synchronous) empties the window, clears the dose counter and
// last dose time, drops out_valid and sets cooldown_ms to 2000 and
// min_confidence_pct to 70. cfg_we writes one register per cycle (index 0 cooldown,
// 1 confidence); the user must do so only while the block is idle (not enforced).
`include "motion_window_event_classifier_defines.svh"

module motion_window_event_classifier (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [15:0] x_accel,
  input  logic signed [15:0] y_accel,
  input  logic signed [15:0] z_accel,
  input  logic [31:0]        time_ms,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [1:0]         event_class,
  output logic [6:0]         confidence_pct,
  output logic [15:0]        dose_total,
  output logic [14:0]        peak_milli_g,
  output logic [9:0]         window_ms
);

  localparam int CW = mwec_pkg::CNT_W;
  localparam int MW = mwec_pkg::MAG_W;

  typedef enum logic [1:0] {S_IDLE, S_MAG, S_DECIDE} state_t;

  state_t             state;
  logic [15:0]        cooldown_ms;
  logic [6:0]         min_confidence_pct;
  logic [CW-1:0]      sample_count;
  logic [MW-1:0]      prev_magnitude;
  logic [MW-1:0]      mag_max;
  logic [MW-1:0]      jerk_max;
  logic signed [15:0] z_lowest;
  logic signed [15:0] z_highest;
  logic [31:0]        window_start_time;
  logic [31:0]        last_dose_time;
  logic [15:0]        dose_counter;
  logic               last_pending;

  logic                  accept;
  logic                  count_full;
  logic                  mag_start;
  logic [MW-1:0]         mag;
  mwec_pkg::mag_stat_t   mag_stat;
  logic [MW-1:0]         jerk;
  logic [6:0]            n7;
  logic [16:0]           z_range;
  logic [19:0]           z_range5;
  logic [19:0]           peak2;
  logic [31:0]           since_dose;
  logic                  in_cooldown;
  logic                  is_act, is_shake, is_drop;
  logic [1:0]            cls;
  logic [6:0]            conf;
  logic                  dose_ok;
  logic                  out_free;
  logic [25:0]           milli_prod;
  logic [12:0]           dur_m;
  logic [29:0]           dur_prod;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign count_full = (sample_count == CW'(mwec_pkg::WINDOW_CAP));
  assign mag_start  = accept && (op == mwec_pkg::OP_SAMPLE) && !count_full;
  assign out_free   = !out_valid || out_ready;

  mwec_mag_unit u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (mag_start),
    .x_in  (x_accel),
    .y_in  (y_accel),
    .z_in  (z_accel),
    .mag   (mag),
    .stat  (mag_stat)
  );

  always_comb begin
    if (sample_count == '0) begin
      jerk = '0;
    end else if (mag > prev_magnitude) begin
      jerk = mag - prev_magnitude;
    end else begin
      jerk = prev_magnitude - mag;
    end

    n7       = 7'(sample_count);
    z_range  = {z_highest[15], z_highest} - {z_lowest[15], z_lowest};
    z_range5 = {3'b000, z_range} * 20'd5;
    peak2    = {3'b000, mag_max, 1'b0};

    // wraps mod 2^32 like the timestamp itself
    since_dose  = window_start_time - last_dose_time;
    in_cooldown = (since_dose < {16'd0, cooldown_ms});

    is_act   = (mag_max > mwec_pkg::P_ACT_LO) && (mag_max < mwec_pkg::P_ACT_HI)
            && (n7 < mwec_pkg::N_ACT_MAX) && (jerk_max > mwec_pkg::J_ACT)
            && (z_range5 > peak2);
    is_shake = (mag_max > mwec_pkg::P_SHAKE_LO)
            && (mag_max < mwec_pkg::P_SHAKE_HI) && (n7 >= mwec_pkg::N_SHAKE_MIN);
    is_drop  = (mag_max > mwec_pkg::P_DROP) && (n7 <= mwec_pkg::N_DROP_MAX);

    if (is_act) begin
      cls  = mwec_pkg::CLS_ACTUATION;
      conf = mwec_pkg::CONF_ACTUATION;
    end else if (is_shake) begin
      cls  = mwec_pkg::CLS_SHAKE;
      conf = mwec_pkg::CONF_SHAKE;
    end else if (is_drop) begin
      cls  = mwec_pkg::CLS_DROP;
      conf = mwec_pkg::CONF_DROP;
    end else begin
      cls  = mwec_pkg::CLS_STATIC;
      conf = mwec_pkg::CONF_STATIC;
    end

    dose_ok = !in_cooldown && (cls == mwec_pkg::CLS_ACTUATION) && (conf > min_confidence_pct);

    milli_prod = {10'd0, mag_max} * mwec_pkg::MILLI_G_SCALE;
    dur_m      = {6'd0, n7} * mwec_pkg::DUR_SCALE;
    dur_prod   = {17'd0, dur_m} * mwec_pkg::RECIP_13;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      cooldown_ms        <= mwec_pkg::COOLDOWN_RESET;
      min_confidence_pct <= mwec_pkg::MIN_CONF_RESET;
      sample_count       <= '0;
      prev_magnitude     <= '0;
      mag_max            <= '0;
      jerk_max           <= '0;
      z_lowest           <= '0;
      z_highest          <= '0;
      window_start_time  <= '0;
      last_dose_time     <= '0;
      dose_counter       <= '0;
      last_pending       <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mwec_pkg::CFG_COOLDOWN: cooldown_ms        <= cfg_data;
          mwec_pkg::CFG_MIN_CONF: min_confidence_pct <= cfg_data[6:0];
          default: ;
        endcase
      end

      // the decision cycle reloads the word itself
      if (out_valid && out_ready && (state != S_DECIDE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == mwec_pkg::OP_CLEAR) begin
              dose_counter <= '0;
            end else if (!count_full) begin
              last_pending <= last_sample;
              state        <= S_MAG;
              if (sample_count == '0) begin
                window_start_time <= time_ms;
                z_lowest          <= z_accel;
                z_highest         <= z_accel;
              end else begin
                if (z_accel < z_lowest) z_lowest <= z_accel;
                if (z_accel > z_highest) z_highest <= z_accel;
              end
            end else if (last_sample) begin
              // full window: the word only closes it
              state <= S_DECIDE;
            end
          end
        end
        S_MAG: begin
          if (mag_stat.done) begin
            if (mag > mag_max) mag_max <= mag;
            if (jerk > jerk_max) jerk_max <= jerk;
            prev_magnitude <= mag;
            sample_count   <= sample_count + CW'(1);
            state          <= last_pending ? S_DECIDE : S_IDLE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            peak_milli_g <= milli_prod[25:11];
            window_ms    <= dur_prod[29:20];
            if (in_cooldown) begin
              status         <= mwec_pkg::ST_COOLDOWN;
              event_class    <= mwec_pkg::CLS_ACTUATION;
              confidence_pct <= mwec_pkg::CONF_NONE;
            end else begin
              status         <= dose_ok ? mwec_pkg::ST_DOSE : mwec_pkg::ST_REJECTED;
              event_class    <= cls;
              confidence_pct <= conf;
            end
            if (dose_ok) begin
              dose_counter   <= dose_counter + 16'd1;
              dose_total     <= dose_counter + 16'd1;
              last_dose_time <= window_start_time;
            end else begin
              dose_total <= dose_counter;
            end
            sample_count      <= '0;
            prev_magnitude    <= '0;
            mag_max           <= '0;
            jerk_max          <= '0;
            z_lowest          <= '0;
            z_highest         <= '0;
            window_start_time <= '0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MWEC_ASSERT_IMP(a_busy_in_mag, mag_stat.busy, state == S_MAG,
    "root unit busy outside the magnitude state")
  `MWEC_ASSERT_IMP(a_dose_is_act, out_valid && status == mwec_pkg::ST_DOSE,
    event_class == mwec_pkg::CLS_ACTUATION, "dose accepted for a non-actuation class")
  `MWEC_ASSERT_IMP(a_skip_no_conf, out_valid && status == mwec_pkg::ST_COOLDOWN,
    confidence_pct == mwec_pkg::CONF_NONE, "cooldown skip with nonzero confidence")
  `MWEC_ASSERT_IMP(a_dose_step, !$stable(dose_counter),
    dose_counter == $past(dose_counter) + 16'd1 || dose_counter == 16'd0,
    "dose counter moved other than by one or a clear")
  `MWEC_ASSERT_NXT(a_decide_emits, state == S_DECIDE && out_free, out_valid,
    "decision cycle did not load the output word")

endmodule

// ===== bench/tb_motion_window_event_classifier.sv =====
`timescale 1ns / 100ps

module tb_motion_window_event_classifier;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_WORDS    = 190;

  localparam int SHAPE_TAP   = 0;
  localparam int SHAPE_SHAKE = 1;
  localparam int SHAPE_DROP  = 2;
  localparam int SHAPE_QUIET = 3;
  localparam int SHAPE_NOISE = 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [6:0]  conf;
    logic [15:0] doses;
    logic [14:0] peak;
    logic [9:0]  dur;
  } window_verdict_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic signed [15:0] x_accel = '0;
  logic signed [15:0] y_accel = '0;
  logic signed [15:0] z_accel = '0;
  logic [31:0] time_ms = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [1:0] event_class;
  logic [6:0] confidence_pct;
  logic [15:0] dose_total;
  logic [14:0] peak_milli_g;
  logic [9:0] window_ms;

  motion_window_event_classifier u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .x_accel        (x_accel),
    .y_accel        (y_accel),
    .z_accel        (z_accel),
    .time_ms        (time_ms),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .event_class    (event_class),
    .confidence_pct (confidence_pct),
    .dose_total     (dose_total),
    .peak_milli_g   (peak_milli_g),
    .window_ms      (window_ms)
  );

  // shadow of the block: registers and window state
  logic [15:0] cool_reg = mwec_pkg::COOLDOWN_RESET;
  logic [6:0]  min_conf_reg = mwec_pkg::MIN_CONF_RESET;
  int unsigned win_n = 0;
  logic [16:0] prev_mag = '0;
  logic [16:0] mag_top = '0;
  logic [16:0] jerk_top = '0;
  logic signed [15:0] z_lo = '0;
  logic signed [15:0] z_hi = '0;
  logic [31:0] win_t0 = '0;
  logic [31:0] last_dose_t = '0;
  logic [15:0] dose_cnt = '0;

  window_verdict_t verdict_q[$];
  window_verdict_t want, got;

  bit calm = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned idle_cycles = 0;
  int words_sent = 0;
  int settings_used = 0;
  int windows_checked = 0;
  int doses_seen = 0;
  int skips_seen = 0;
  int bad_results = 0;
  logic [3:0] classes_seen = '0;
  logic [31:0] clock_ms = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(50, 150);
  endfunction

  // random value of magnitude lo..hi with random sign
  function automatic logic signed [15:0] swing(input int unsigned lo, input int unsigned hi);
    int v;
    v = int'($urandom_range(lo, hi));
    if ($urandom_range(0, 1) != 0) v = -v;
    return 16'(v);
  endfunction

  function automatic logic [16:0] floor_root(input longint v);
    logic [16:0] r;
    logic [16:0] trial;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = r | (17'd1 << b);
      if (longint'(trial) * longint'(trial) <= v) r = trial;
    end
    return r;
  endfunction

  task automatic classify_word(input logic o, input logic signed [15:0] x, y, z,
                               input logic [31:0] t, input logic last);
    longint xs, ys, zs;
    logic [16:0] mag, jerk;
    logic [31:0] p, zr;
    window_verdict_t v;
    if (o == mwec_pkg::OP_CLEAR) begin
      dose_cnt = '0;
      return;
    end
    if (win_n < mwec_pkg::WINDOW_CAP) begin
      xs = x;
      ys = y;
      zs = z;
      mag = floor_root(xs * xs + ys * ys + zs * zs);
      jerk = '0;
      if (win_n == 0) begin
        win_t0 = t;
        z_lo = z;
        z_hi = z;
      end else begin
        jerk = (mag > prev_mag) ? mag - prev_mag : prev_mag - mag;
        if (z < z_lo) z_lo = z;
        if (z > z_hi) z_hi = z;
      end
      if (mag > mag_top) mag_top = mag;
      if (jerk > jerk_top) jerk_top = jerk;
      prev_mag = mag;
      win_n++;
    end
    if (!last) return;

    p = 32'(mag_top);
    zr = 32'(int'(z_hi) - int'(z_lo));
    if ((win_t0 - last_dose_t) < {16'd0, cool_reg}) begin
      v.status = mwec_pkg::ST_COOLDOWN;
      v.kind = mwec_pkg::CLS_ACTUATION;
      v.conf = mwec_pkg::CONF_NONE;
    end else begin
      if (p > mwec_pkg::P_ACT_LO && p < mwec_pkg::P_ACT_HI && win_n < mwec_pkg::N_ACT_MAX &&
          jerk_top > mwec_pkg::J_ACT && zr * 5 > p * 2) begin
        v.kind = mwec_pkg::CLS_ACTUATION;
        v.conf = mwec_pkg::CONF_ACTUATION;
      end else if (p > mwec_pkg::P_SHAKE_LO && p < mwec_pkg::P_SHAKE_HI &&
                   win_n >= mwec_pkg::N_SHAKE_MIN) begin
        v.kind = mwec_pkg::CLS_SHAKE;
        v.conf = mwec_pkg::CONF_SHAKE;
      end else if (p > mwec_pkg::P_DROP && win_n <= mwec_pkg::N_DROP_MAX) begin
        v.kind = mwec_pkg::CLS_DROP;
        v.conf = mwec_pkg::CONF_DROP;
      end else begin
        v.kind = mwec_pkg::CLS_STATIC;
        v.conf = mwec_pkg::CONF_STATIC;
      end
      v.status = mwec_pkg::ST_REJECTED;
      if (v.kind == mwec_pkg::CLS_ACTUATION && v.conf > min_conf_reg) begin
        dose_cnt = dose_cnt + 16'd1;
        last_dose_t = win_t0;
        v.status = mwec_pkg::ST_DOSE;
      end
    end
    v.doses = dose_cnt;
    v.peak = 15'((p * 1000) / 2048);
    v.dur = 10'((win_n * 1000) / 104);
    verdict_q.push_back(v);

    win_n = 0;
    prev_mag = '0;
    mag_top = '0;
    jerk_top = '0;
    z_lo = '0;
    z_hi = '0;
    win_t0 = '0;
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      classify_word(op, x_accel, y_accel, z_accel, time_ms, last_sample);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {status, event_class, confidence_pct, dose_total, peak_milli_g, window_ms};
      if (verdict_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: result with none expected: status %0d class %0d doses %0d",
                   $time, got.status, got.kind, got.doses);
      end else begin
        want = verdict_q.pop_front();
        windows_checked++;
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10)
            $display({"%0t: mismatch exp/got: status %0d/%0d class %0d/%0d conf %0d/%0d ",
                      "doses %0d/%0d peak %0d/%0d dur %0d/%0d"}, $time,
                     want.status, got.status, want.kind, got.kind, want.conf,
                     got.conf, want.doses, got.doses, want.peak, got.peak, want.dur, got.dur);
        end else if (want.status == mwec_pkg::ST_DOSE) begin
          doses_seen++;
        end else if (want.status == mwec_pkg::ST_COOLDOWN) begin
          skips_seen++;
        end else begin
          classes_seen[want.kind] = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      ready_hold = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               idle_cycles, verdict_q.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // valid stays high on return so back-to-back words never drop it
  task automatic send_word(input logic o, input logic signed [15:0] x, y, z,
                           input logic [31:0] t, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    x_accel <= x;
    y_accel <= y;
    z_accel <= z;
    time_ms <= t;
    last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // hold input, let every pending result drain, then let trailing samples finish
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] cool, input logic [6:0] conf);
    cfg_we <= 1'b1;
    cfg_index <= mwec_pkg::CFG_COOLDOWN;
    cfg_data <= cool;
    @(posedge clk);
    cfg_index <= mwec_pkg::CFG_MIN_CONF;
    cfg_data <= {9'd0, conf};
    @(posedge clk);
    cfg_we <= 1'b0;
    cool_reg = cool;
    min_conf_reg = conf;
    settings_used++;
  endtask

  task automatic send_window();
    int unsigned r, shape, len, mark;
    logic signed [15:0] x, y, z;
    r = $urandom_range(0, 99);
    if (r < 35) shape = SHAPE_TAP;
    else if (r < 55) shape = SHAPE_SHAKE;
    else if (r < 70) shape = SHAPE_DROP;
    else if (r < 85) shape = SHAPE_QUIET;
    else shape = SHAPE_NOISE;
    case (shape)
      SHAPE_TAP:   len = $urandom_range(2, 28);
      SHAPE_SHAKE: len = $urandom_range(12, 40);
      SHAPE_DROP:  len = $urandom_range(1, 14);
      SHAPE_QUIET: len = $urandom_range(1, 30);
      default:     len = $urandom_range(1, 40);
    endcase
    mark = (len > 1) ? $urandom_range(1, len - 1) : 0;

    // gap before the window: around the cooldown, sometimes far past it
    r = $urandom_range(0, 99);
    if (r < 60) clock_ms += $urandom_range(0, 2500);
    else if (r < 90) clock_ms += $urandom_range(2500, 70000);
    else clock_ms += $urandom;

    for (int i = 0; i < len; i++) begin
      x = swing(0, 200);
      y = swing(0, 200);
      z = 16'(2048) + swing(0, 200);
      case (shape)
        SHAPE_TAP: begin
          if (i == mark) z = 16'($urandom_range(6000, 21000));
          else z = -16'($urandom_range(1500, 2600));
        end
        SHAPE_SHAKE: begin
          x = swing(3800, 8500);
          z = swing(0, 400);
        end
        SHAPE_DROP: begin
          if (i == mark) begin
            x = swing(12000, 32767);
            y = swing(12000, 32767);
            z = swing(12000, 32767);
          end
        end
        SHAPE_NOISE: begin
          x = 16'($urandom);
          y = 16'($urandom);
          z = 16'($urandom);
        end
        default: ;
      endcase
      // stray clear inside or just before a window, junk payload
      if ($urandom_range(0, 49) == 0)
        send_word(mwec_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                  1'($urandom));
      send_word(mwec_pkg::OP_SAMPLE, x, y, z, clock_ms, i == len - 1);
      clock_ms += $urandom_range(8, 12);
    end
  endtask

  // actuation, shake and drop windows plus two cooldown skips at reset settings, with full-scale samples and timestamps
  task automatic test_directed_classes();
    send_word(mwec_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b1);
    send_word(mwec_pkg::OP_SAMPLE, 16'sd0, 16'sd0, -16'sd2048, 32'd5000, 1'b0);
    send_word(mwec_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd14000, 32'd5010, 1'b1);
    send_word(mwec_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd2048, 32'd6000, 1'b1);
    for (int i = 0; i < 16; i++)
      send_word(mwec_pkg::OP_SAMPLE, 16'sd5000, 16'sd0, 16'sd0, 32'd10000 + 32'(i * 10),
                i == 15);
    send_word(mwec_pkg::OP_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF, 1'b0);
    send_word(mwec_pkg::OP_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767, 32'd0, 1'b1);
  endtask

  // clear must zero the count and not end a window, even with last_sample set
  task automatic test_dose_clear();
    send_word(mwec_pkg::OP_CLEAR, 16'sd32767, 16'sh8000, 16'sd32767, 32'hFFFF_FFFF, 1'b1);
    send_word(mwec_pkg::OP_SAMPLE, 16'sd0, 16'sd0, -16'sd2048, 32'd30000, 1'b0);
    send_word(mwec_pkg::OP_SAMPLE, 16'sd0, 16'sd0, 16'sd14000, 32'd30010, 1'b1);
  endtask

  task automatic test_register_sweep();
    logic [15:0] cool_set [8];
    logic [6:0]  conf_set [8];
    int start;
    cool_set = '{16'd0, 16'd65535, 16'd2000, 16'd1, 16'd0, 16'd0, 16'd500, 16'd2000};
    conf_set = '{7'd0, 7'd100, 7'd85, 7'd84, 7'd70, 7'd0, 7'd0, 7'd70};
    cool_set[5] = 16'($urandom);
    conf_set[5] = 7'($urandom_range(0, 100));
    conf_set[6] = 7'($urandom_range(0, 100));
    clock_ms = 32'd40000;
    for (int k = 0; k < 8; k++) begin
      settle_block();
      set_config(cool_set[k], conf_set[k]);
      calm = (k == 4);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) send_window();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    calm = 1'b1;
    test_directed_classes();
    calm = 1'b0;
    test_dose_clear();
    test_register_sweep();
    settle_block();
    $display("%0d words over %0d register settings, %0d windows checked",
             words_sent, settings_used, windows_checked);
    $display("%0d doses, %0d cooldown skips, classified-not-dosed classes %b, %0d bad",
             doses_seen, skips_seen, classes_seen, bad_results);
    if (bad_results == 0 && verdict_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
